// File: src/rrfd_pkg.sv
// Shared types and constants of the rectangle frame decoder.
`timescale 1ns / 1ps
package rrfd_pkg;

   localparam int CAP_W       = 18;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 5;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = 18'd4096;

   localparam logic [1:0] KIND_RECT = 2'd0;
   localparam logic [1:0] KIND_RUN  = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   localparam logic [2:0] ERR_SHORT_HDR = 3'd1;
   localparam logic [2:0] ERR_ZERO_W    = 3'd2;
   localparam logic [2:0] ERR_TOO_WIDE  = 3'd3;
   localparam logic [2:0] ERR_OVERRUN   = 3'd4;
   localparam logic [2:0] ERR_PIX_SHORT = 3'd5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] rect_x;
      logic [15:0] rect_y;
      logic [15:0] rect_w;
      logic [15:0] rect_h;
      logic [15:0] pixel;
      logic [7:0]  repeat_res;
      logic [7:0]  rect_total;
      logic [2:0]  error_code;
   } rrfd_res_type;

endpackage

// File: src/rrfd_req_if.sv
// Input channel: one frame byte per word.
`timescale 1ns / 1ps
interface rrfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_blob;

   modport source (output valid, output data_byte, output end_of_blob, input ready);
   modport sink (input valid, input data_byte, input end_of_blob, output ready);
endinterface

// File: src/rrfd_rsp_if.sv
// Result channel: one decoded result per word.
`timescale 1ns / 1ps
interface rrfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] rect_x;
   logic [15:0] rect_y;
   logic [15:0] rect_w;
   logic [15:0] rect_h;
   logic [15:0] pixel;
   logic [7:0]  repeat_res;
   logic [7:0]  rect_total;
   logic [2:0]  error_code;

   modport source (output valid, output kind, output rect_x, output rect_y, output rect_w,
                   output rect_h, output pixel, output repeat_res, output rect_total,
                   output error_code, input ready);
   modport sink (input valid, input kind, input rect_x, input rect_y, input rect_w,
                 input rect_h, input pixel, input repeat_res, input rect_total,
                 input error_code, output ready);
endinterface

// File: src/rle_rect_frame_decoder.sv
// Top level: streaming decoder of run-length coded rectangle frames with 16-bit pixels.
// Output: the first result of a byte is on rsp_bus in the cycle after the byte is accepted
// when no earlier result waits.
// Throughput: one byte per cycle; a byte yields at most three results, queued in a
// five-word result queue, and req_bus.ready drops while three or more results wait.
// Reset (synchronous): parser returns to waiting for a count byte, queue empties,
// strip capacity returns to 4096.
`timescale 1ns / 1ps
module rle_rect_frame_decoder (
   input  logic                            clock,
   input  logic                            reset,
   rrfd_req_if.sink                        req_bus,
   rrfd_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rrfd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rrfd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rrfd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import rrfd_pkg::*;

   localparam logic [2:0] PH_COUNT   = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_SKIP    = 3'd3;
   localparam logic [2:0] PH_ERROR   = 3'd4;

   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [2:0]        phase_ff, phase_in;
   logic [3:0]        hdr_idx_ff, hdr_idx_in;
   logic [63:0]       hdr_ff, hdr_in;
   logic [31:0]       pay_ff, pay_in;
   logic [31:0]       pix_ff, pix_in;
   logic [7:0]        op_left_ff, op_left_in;
   logic              op_run_ff, op_run_in;
   logic [7:0]        held_ff, held_in;
   logic [1:0]        bph_ff, bph_in;
   logic [7:0]        rects_left_ff, rects_left_in;
   logic [7:0]        rect_count_ff, rect_count_in;

   rrfd_res_type      q_ff [QUEUE_DEPTH];
   rrfd_res_type      q_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   rrfd_res_type      res [3];
   logic [1:0]        n_res;
   logic              acc, pop, finish, fail;
   logic [2:0]        fail_code;
   logic [7:0]        b;
   logic [15:0]       w, h;
   logic [31:0]       pay_full, area, pay_dec, pix_dec;
   logic [7:0]        rep, op_dec;
   logic [QCNT_W-1:0] cnt_pop;

   assign acc = req_bus.valid && req_bus.ready;
   assign pop = rsp_bus.valid && rsp_bus.ready;
   assign req_bus.ready = (cnt_ff <= QCNT_W'(QUEUE_DEPTH - 3));

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? '0 : CSR_DATA_W'(cap_ff);

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         cap_in = csr_pwdata[CAP_W-1:0];
      end
   end

   assign b        = req_bus.data_byte;
   assign w        = hdr_ff[47:32];
   assign h        = hdr_ff[63:48];
   assign pay_full = {b, pay_ff[23:0]};
   assign area     = w * h;
   assign pay_dec  = pay_ff - 32'd1;
   assign op_dec   = op_left_ff - 8'd1;

   always_comb begin
      phase_in      = phase_ff;
      hdr_idx_in    = hdr_idx_ff;
      hdr_in        = hdr_ff;
      pay_in        = pay_ff;
      pix_in        = pix_ff;
      op_left_in    = op_left_ff;
      op_run_in     = op_run_ff;
      held_in       = held_ff;
      bph_in        = bph_ff;
      rects_left_in = rects_left_ff;
      rect_count_in = rect_count_ff;
      res[0]        = '0;
      res[1]        = '0;
      res[2]        = '0;
      n_res         = 2'd0;
      finish        = 1'b0;
      fail          = 1'b0;
      fail_code     = ERR_SHORT_HDR;
      rep           = 8'd1;
      pix_dec       = pix_ff;

      if (acc) begin
         unique case (phase_ff)
            PH_COUNT: begin
               rect_count_in = b;
               rects_left_in = b;
               if (b == 8'd0) begin
                  res[n_res].kind = KIND_DONE;
                  n_res           = n_res + 2'd1;
               end else begin
                  phase_in   = PH_HEADER;
                  hdr_idx_in = 4'd0;
               end
            end
            PH_HEADER: begin
               if (!hdr_idx_ff[3]) begin
                  hdr_in[{hdr_idx_ff[2:0], 3'b000} +: 8] = b;
               end else begin
                  pay_in[{hdr_idx_ff[1:0], 3'b000} +: 8] = b;
               end
               hdr_idx_in = hdr_idx_ff + 4'd1;
               if (hdr_idx_ff == 4'd11) begin
                  hdr_idx_in = 4'd0;
                  if (w == 16'd0) begin
                     fail      = 1'b1;
                     fail_code = ERR_ZERO_W;
                  end else if ({1'b0, w, 1'b0} > cap_ff) begin
                     fail      = 1'b1;
                     fail_code = ERR_TOO_WIDE;
                  end else begin
                     res[n_res].kind   = KIND_RECT;
                     res[n_res].rect_x = hdr_ff[15:0];
                     res[n_res].rect_y = hdr_ff[31:16];
                     res[n_res].rect_w = w;
                     res[n_res].rect_h = h;
                     n_res             = n_res + 2'd1;
                     pix_in            = area;
                     bph_in            = 2'd0;
                     op_left_in        = 8'd0;
                     op_run_in         = 1'b0;
                     if (area == 32'd0) begin
                        if (pay_full == 32'd0) begin
                           finish = 1'b1;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end else if (pay_full == 32'd0) begin
                        fail      = 1'b1;
                        fail_code = ERR_PIX_SHORT;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end
               end
            end
            PH_PAYLOAD: begin
               pay_in = pay_dec;
               unique case (bph_ff)
                  2'd0: begin
                     op_run_in  = b[7];
                     op_left_in = b[7] ? (b - 8'd126) : (b + 8'd1);
                     bph_in     = 2'd1;
                  end
                  2'd1: begin
                     held_in = b;
                     bph_in  = 2'd2;
                  end
                  default: begin
                     if (op_run_ff) begin
                        rep        = ({24'd0, op_left_ff} < pix_ff) ? op_left_ff : pix_ff[7:0];
                        op_left_in = 8'd0;
                     end else begin
                        op_left_in = op_dec;
                     end
                     pix_dec               = pix_ff - {24'd0, rep};
                     pix_in                = pix_dec;
                     res[n_res].kind       = KIND_RUN;
                     res[n_res].pixel      = {held_ff, b};
                     res[n_res].repeat_res = rep;
                     n_res                 = n_res + 2'd1;
                     bph_in                = (op_left_in != 8'd0) ? 2'd1 : 2'd0;
                  end
               endcase
               if (pix_in == 32'd0) begin
                  if (pay_dec == 32'd0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end else if (pay_dec == 32'd0) begin
                  fail      = 1'b1;
                  fail_code = ERR_PIX_SHORT;
               end
            end
            PH_SKIP: begin
               pay_in = pay_dec;
               if (pay_dec == 32'd0) begin
                  finish = 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (finish) begin
            rects_left_in = rects_left_ff - 8'd1;
            if (rects_left_in == 8'd0) begin
               res[n_res].kind       = KIND_DONE;
               res[n_res].rect_total = rect_count_ff;
               n_res                 = n_res + 2'd1;
               phase_in              = PH_COUNT;
            end else begin
               phase_in   = PH_HEADER;
               hdr_idx_in = 4'd0;
            end
         end

         if (fail) begin
            res[n_res].kind       = KIND_ERR;
            res[n_res].error_code = fail_code;
            n_res                 = n_res + 2'd1;
            phase_in              = PH_ERROR;
         end

         if (req_bus.end_of_blob) begin
            if (phase_in == PH_HEADER) begin
               res[n_res].kind       = KIND_ERR;
               res[n_res].error_code = ERR_SHORT_HDR;
               n_res                 = n_res + 2'd1;
            end else if (phase_in == PH_PAYLOAD || phase_in == PH_SKIP) begin
               res[n_res].kind       = KIND_ERR;
               res[n_res].error_code = ERR_OVERRUN;
               n_res                 = n_res + 2'd1;
            end
            phase_in   = PH_COUNT;
            hdr_idx_in = 4'd0;
            bph_in     = 2'd0;
            op_left_in = 8'd0;
         end
      end
   end

   assign cnt_pop = cnt_ff - QCNT_W'(pop);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_in[i] = q_ff[i];
         if (pop && i < QUEUE_DEPTH - 1) begin
            q_in[i] = q_ff[i + 1];
         end
         if (n_res != 2'd0 && QCNT_W'(i) == cnt_pop) begin
            q_in[i] = res[0];
         end
         if (n_res >= 2'd2 && QCNT_W'(i) == cnt_pop + QCNT_W'(1)) begin
            q_in[i] = res[1];
         end
         if (n_res == 2'd3 && QCNT_W'(i) == cnt_pop + QCNT_W'(2)) begin
            q_in[i] = res[2];
         end
      end
      cnt_in = cnt_pop + QCNT_W'(n_res);
   end

   assign rsp_bus.valid      = (cnt_ff != '0);
   assign rsp_bus.kind       = q_ff[0].kind;
   assign rsp_bus.rect_x     = q_ff[0].rect_x;
   assign rsp_bus.rect_y     = q_ff[0].rect_y;
   assign rsp_bus.rect_w     = q_ff[0].rect_w;
   assign rsp_bus.rect_h     = q_ff[0].rect_h;
   assign rsp_bus.pixel      = q_ff[0].pixel;
   assign rsp_bus.repeat_res = q_ff[0].repeat_res;
   assign rsp_bus.rect_total = q_ff[0].rect_total;
   assign rsp_bus.error_code = q_ff[0].error_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= CAP_RESET;
         phase_ff      <= PH_COUNT;
         hdr_idx_ff    <= '0;
         hdr_ff        <= '0;
         pay_ff        <= '0;
         pix_ff        <= '0;
         op_left_ff    <= '0;
         op_run_ff     <= 1'b0;
         held_ff       <= '0;
         bph_ff        <= '0;
         rects_left_ff <= '0;
         rect_count_ff <= '0;
         cnt_ff        <= '0;
      end else begin
         cap_ff        <= cap_in;
         phase_ff      <= phase_in;
         hdr_idx_ff    <= hdr_idx_in;
         hdr_ff        <= hdr_in;
         pay_ff        <= pay_in;
         pix_ff        <= pix_in;
         op_left_ff    <= op_left_in;
         op_run_ff     <= op_run_in;
         held_ff       <= held_in;
         bph_ff        <= bph_in;
         rects_left_ff <= rects_left_in;
         rect_count_ff <= rect_count_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule

// File: src/rrfd_checker.sv
// Port-level checks of the rectangle frame decoder, bound to its top level.
`timescale 1ns / 1ps
module rrfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_rect_w,
   input logic [7:0]  rsp_repeat_res,
   input logic [2:0]  rsp_error_code
);
   import rrfd_pkg::*;

   a_idle_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result word shown right after reset");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ERR |->
         rsp_error_code == ERR_SHORT_HDR || rsp_error_code == ERR_ZERO_W ||
         rsp_error_code == ERR_TOO_WIDE || rsp_error_code == ERR_OVERRUN ||
         rsp_error_code == ERR_PIX_SHORT)
      else $error("error word with unknown code");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RUN |-> rsp_repeat_res != 8'd0 && rsp_repeat_res <= 8'd129)
      else $error("pixel run length out of range");

   a_rect_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RECT |-> rsp_rect_w != 16'd0)
      else $error("rectangle start with zero width");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
      else $error("stalled result word changed");

endmodule

bind rle_rect_frame_decoder rrfd_checker u_rrfd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_kind       (rsp_bus.kind),
   .rsp_rect_w     (rsp_bus.rect_w),
   .rsp_repeat_res (rsp_bus.repeat_res),
   .rsp_error_code (rsp_bus.error_code)
);
